### rtl/gbn_pkg.sv
// Shared types and constants for the Go-Back-N sliding window core.
// No dependencies; used by gbn_ctrl, gbn_dpath and go_back_n_sliding_window_core.
package gbn_pkg;

	// default window and payload sizes
	localparam int MAX_SEQ_DEF      = 7;
	localparam int PAYLOAD_BITS_DEF = 32;

	// at most this many result words per event
	localparam int RESULT_CAP = 8;

	// event codes on opcode
	typedef enum logic [1:0] {
		OP_PACKET    = 2'd0,
		OP_FRAME     = 2'd1,
		OP_CKSUM_ERR = 2'd2,
		OP_TIMEOUT   = 2'd3
	} op_t;

	// result word kinds
	typedef enum logic [1:0] {
		KIND_XMIT    = 2'd0,
		KIND_DELIVER = 2'd1,
		KIND_STOP    = 2'd2,
		KIND_STATUS  = 2'd3
	} kind_t;

	// controller states
	typedef enum logic [1:0] {
		ST_IDLE   = 2'd0,
		ST_DECIDE = 2'd1,
		ST_WALK   = 2'd2
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic capture;
		logic decide;
		logic step;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic walk_req;
		logic walk_last;
	} sts_t;

endpackage

### rtl/gbn_ctrl.sv
// Event sequencer for the Go-Back-N core: capture, decide, window walk.
// Depends on gbn_pkg (state, command and status types).
module gbn_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  gbn_pkg::sts_t sts,
	output gbn_pkg::cmd_t cmd,
	output logic          busy
);

	gbn_pkg::state_t state_q;
	gbn_pkg::state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gbn_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			gbn_pkg::ST_IDLE: begin
				if (start) state_d = gbn_pkg::ST_DECIDE;
			end
			gbn_pkg::ST_DECIDE: begin
				state_d = sts.walk_req ? gbn_pkg::ST_WALK : gbn_pkg::ST_IDLE;
			end
			gbn_pkg::ST_WALK: begin
				if (sts.walk_last) state_d = gbn_pkg::ST_IDLE;
			end
			default: begin
				state_d = gbn_pkg::ST_IDLE;
			end
		endcase
	end

	// commands
	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		case (state_q)
			gbn_pkg::ST_IDLE: begin
				busy        = 1'b0;
				cmd.capture = start;
			end
			gbn_pkg::ST_DECIDE: begin
				cmd.decide = 1'b1;
			end
			gbn_pkg::ST_WALK: begin
				cmd.step = 1'b1;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

endmodule

### rtl/gbn_dpath.sv
// Datapath of the Go-Back-N core: window registers, send buffer, result register.
// Depends on gbn_pkg (codes, command and status types); driven by gbn_ctrl.
module gbn_dpath #(
	parameter int MAX_SEQ      = gbn_pkg::MAX_SEQ_DEF,
	parameter int PAYLOAD_BITS = gbn_pkg::PAYLOAD_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  gbn_pkg::cmd_t cmd,
	output gbn_pkg::sts_t sts,
	input  logic [1:0]    opcode,
	input  logic [2:0]    frame_seq,
	input  logic [2:0]    frame_ack,
	input  logic [31:0]   payload,
	output logic          strobe,
	output logic [1:0]    kind,
	output logic [2:0]    seq_out,
	output logic [2:0]    ack_out,
	output logic [31:0]   data_out,
	output logic          network_enabled,
	output logic [2:0]    outstanding_count,
	output logic          last
);

	localparam int SW    = $clog2(MAX_SEQ + 1);
	localparam int EW    = (SW > 3) ? SW : 3;
	localparam int DW    = (PAYLOAD_BITS < 32) ? PAYLOAD_BITS : 32;
	localparam int DEPTH = MAX_SEQ + 1;
	localparam int CAP   = gbn_pkg::RESULT_CAP;
	localparam int KMAX  = (MAX_SEQ > CAP) ? MAX_SEQ : CAP;
	localparam int KW    = $clog2(KMAX + 1);
	localparam logic [SW-1:0] TOP = SW'(MAX_SEQ);

	// sequence arithmetic modulo MAX_SEQ+1
	function automatic logic [SW-1:0] seq_inc(input logic [SW-1:0] x);
		return (x == TOP) ? '0 : x + 1'b1;
	endfunction

	function automatic logic [SW-1:0] seq_dec(input logic [SW-1:0] x);
		return (x == '0) ? TOP : x - 1'b1;
	endfunction

	// sequence value onto a 3-bit result field
	function automatic logic [2:0] fit3(input logic [SW-1:0] x);
		logic [EW-1:0] t;
		t = EW'(x);
		return t[2:0];
	endfunction

	// captured event word
	gbn_pkg::op_t  op_q;
	logic [2:0]    fseq_q;
	logic [2:0]    fack_q;
	logic [DW-1:0] data_q;

	// window state
	logic [SW-1:0] nts_q;
	logic [SW-1:0] old_q;
	logic [SW-1:0] exp_q;
	logic [SW-1:0] outs_q;

	// walk state
	logic [SW-1:0] wptr_q;
	logic [SW-1:0] wcnt_q;
	logic [KW-1:0] steps_q;

	// send buffer
	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rdata_q;
	logic [SW-1:0] rd_addr;

	// result register
	logic          strobe_q;
	logic [1:0]    kind_q;
	logic [2:0]    seq_q;
	logic [2:0]    ack_q;
	logic [31:0]   dout_q;
	logic          ne_q;
	logic [2:0]    cnt_q;
	logic          last_q;

	// decode terms
	logic          space;
	logic          deliver;
	logic          ack_ok;
	logic [EW-1:0] fack_x;
	logic [SW-1:0] ack_s;
	logic [SW:0]   dsum;
	logic [SW-1:0] ack_gap;
	logic          frees;
	logic [KW-1:0] nstop;
	logic [KW-1:0] cap_left;
	logic [KW-1:0] ack_steps;
	logic [KW-1:0] tmo_steps;
	logic [KW-1:0] steps_c;
	logic [SW:0]   ssum;
	logic [SW-1:0] tmo_nts;
	logic [SW-1:0] outs_inc;
	logic [2:0]    piggy;
	logic          walk_last;

	// event decode
	always_comb begin
		space    = outs_q < TOP;
		outs_inc = outs_q + 1'b1;
		piggy    = fit3(seq_dec(exp_q));
		deliver  = (op_q == gbn_pkg::OP_FRAME) && (EW'(fseq_q) == EW'(exp_q));

		// ack distance from the oldest outstanding frame
		fack_x  = EW'(fack_q);
		ack_ok  = fack_x <= EW'(TOP);
		ack_s   = fack_x[SW-1:0];
		dsum    = {1'b0, ack_s} + (SW+1)'(DEPTH) - {1'b0, old_q};
		ack_gap = (dsum >= (SW+1)'(DEPTH)) ? SW'(dsum - (SW+1)'(DEPTH)) : dsum[SW-1:0];
		frees   = ack_ok && (ack_gap < outs_q);
		nstop   = frees ? (KW'(ack_gap) + 1'b1) : '0;

		// walk lengths, clipped at the result cap
		cap_left  = KW'(CAP) - KW'(deliver);
		ack_steps = (nstop < cap_left) ? nstop : cap_left;
		tmo_steps = (KW'(outs_q) < KW'(CAP)) ? KW'(outs_q) : KW'(CAP);
		case (op_q)
			gbn_pkg::OP_FRAME:   steps_c = ack_steps;
			gbn_pkg::OP_TIMEOUT: steps_c = tmo_steps;
			default:             steps_c = '0;
		endcase

		// resend restarts at the oldest frame
		ssum    = {1'b0, old_q} + {1'b0, outs_q};
		tmo_nts = (ssum >= (SW+1)'(DEPTH)) ? SW'(ssum - (SW+1)'(DEPTH)) : ssum[SW-1:0];

		walk_last = steps_q == KW'(1);
	end

	assign sts.walk_req  = steps_c != '0;
	assign sts.walk_last = walk_last;

	// event capture
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q   <= gbn_pkg::op_t'(opcode);
			fseq_q <= frame_seq;
			fack_q <= frame_ack;
			data_q <= payload[DW-1:0];
		end
	end

	// window and walk registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nts_q   <= '0;
			old_q   <= '0;
			exp_q   <= '0;
			outs_q  <= '0;
			wptr_q  <= '0;
			wcnt_q  <= '0;
			steps_q <= '0;
		end else if (cmd.decide) begin
			case (op_q)
				gbn_pkg::OP_PACKET: begin
					if (space) begin
						outs_q <= outs_inc;
						nts_q  <= seq_inc(nts_q);
					end
				end
				gbn_pkg::OP_FRAME: begin
					if (deliver) exp_q <= seq_inc(exp_q);
					if (frees) begin
						old_q  <= seq_inc(ack_s);
						outs_q <= outs_q - ack_gap - 1'b1;
					end
				end
				gbn_pkg::OP_TIMEOUT: begin
					nts_q <= tmo_nts;
				end
				default: begin
					nts_q <= nts_q;
				end
			endcase
			wptr_q  <= old_q;
			wcnt_q  <= outs_q;
			steps_q <= steps_c;
		end else if (cmd.step) begin
			wptr_q  <= seq_inc(wptr_q);
			wcnt_q  <= wcnt_q - 1'b1;
			steps_q <= steps_q - 1'b1;
		end
	end

	// send buffer: one write port, one registered read port read one ahead
	assign rd_addr = cmd.step ? seq_inc(wptr_q) : old_q;

	always_ff @(posedge clk) begin
		if (cmd.decide && (op_q == gbn_pkg::OP_PACKET) && space) begin
			mem[nts_q] <= data_q;
		end
		rdata_q <= mem[rd_addr];
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= cmd.step || (cmd.decide && (deliver || !sts.walk_req));
		end
	end

	// result word
	always_ff @(posedge clk) begin
		if (cmd.decide) begin
			if ((op_q == gbn_pkg::OP_PACKET) && space) begin
				kind_q <= gbn_pkg::KIND_XMIT;
				seq_q  <= fit3(nts_q);
				ack_q  <= piggy;
				dout_q <= 32'(data_q);
				cnt_q  <= fit3(outs_inc);
				ne_q   <= outs_inc < TOP;
				last_q <= 1'b1;
			end else if (deliver) begin
				kind_q <= gbn_pkg::KIND_DELIVER;
				seq_q  <= '0;
				ack_q  <= '0;
				dout_q <= 32'(data_q);
				cnt_q  <= fit3(outs_q);
				ne_q   <= !sts.walk_req && space;
				last_q <= !sts.walk_req;
			end else begin
				kind_q <= gbn_pkg::KIND_STATUS;
				seq_q  <= '0;
				ack_q  <= '0;
				dout_q <= '0;
				cnt_q  <= fit3(outs_q);
				ne_q   <= space;
				last_q <= 1'b1;
			end
		end else if (cmd.step) begin
			seq_q  <= fit3(wptr_q);
			last_q <= walk_last;
			ne_q   <= walk_last && space;
			if (op_q == gbn_pkg::OP_TIMEOUT) begin
				kind_q <= gbn_pkg::KIND_XMIT;
				ack_q  <= piggy;
				dout_q <= 32'(rdata_q);
				cnt_q  <= fit3(outs_q);
			end else begin
				kind_q <= gbn_pkg::KIND_STOP;
				ack_q  <= '0;
				dout_q <= '0;
				cnt_q  <= walk_last ? fit3(outs_q) : fit3(wcnt_q - 1'b1);
			end
		end
	end

	assign strobe            = strobe_q;
	assign kind              = kind_q;
	assign seq_out           = seq_q;
	assign ack_out           = ack_q;
	assign data_out          = dout_q;
	assign network_enabled   = ne_q;
	assign outstanding_count = cnt_q;
	assign last              = last_q;

endmodule

### rtl/go_back_n_sliding_window_core.sv
// Top level of the Go-Back-N sliding window core (sender and receiver of one link end).
// Depends on gbn_pkg, gbn_ctrl and gbn_dpath.
//
// An event is taken when start is high and busy is low. It is decoded in the next cycle;
// results then come out one per cycle, each on the result ports for exactly one cycle
// with strobe high, and the receiver cannot stall them. Packet, checksum-error and
// plain status events give their one result from the result register after the decode.
// Acknowledgements and timeouts walk the window one entry per cycle over N entries, N
// the timers stopped or frames resent, up to the smaller of MAX_SEQ and RESULT_CAP (7 at
// the default window): one result word leaves per cycle, a resend reads one send-buffer
// entry per cycle. A delivered payload comes from the decode step, ahead of the walk.
// last marks the final result of an event; network_enabled is valid on it only.
// busy falls as the final result appears, so the next event may follow at once.
module go_back_n_sliding_window_core #(
	parameter int MAX_SEQ      = gbn_pkg::MAX_SEQ_DEF,
	parameter int PAYLOAD_BITS = gbn_pkg::PAYLOAD_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  opcode,
	input  logic [2:0]  frame_seq,
	input  logic [2:0]  frame_ack,
	input  logic [31:0] payload,
	output logic        strobe,
	output logic [1:0]  kind,
	output logic [2:0]  seq_out,
	output logic [2:0]  ack_out,
	output logic [31:0] data_out,
	output logic        network_enabled,
	output logic [2:0]  outstanding_count,
	output logic        last
);

	gbn_pkg::cmd_t cmd;
	gbn_pkg::sts_t sts;

	// sequencer
	gbn_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	// window state, send buffer and result register
	gbn_dpath #(
		.MAX_SEQ      (MAX_SEQ),
		.PAYLOAD_BITS (PAYLOAD_BITS)
	) u_dpath (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.sts               (sts),
		.opcode            (opcode),
		.frame_seq         (frame_seq),
		.frame_ack         (frame_ack),
		.payload           (payload),
		.strobe            (strobe),
		.kind              (kind),
		.seq_out           (seq_out),
		.ack_out           (ack_out),
		.data_out          (data_out),
		.network_enabled   (network_enabled),
		.outstanding_count (outstanding_count),
		.last              (last)
	);

endmodule
